/* rtl/kts_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package kts_pkg;

  // Item kinds carried on in_tuser
  typedef enum logic [1:0] {
    KIND_SEED = 2'd0,
    KIND_KEY  = 2'd1,
    KIND_RAND = 2'd2
  } kind_t;

  // Seed values used when the hours/minutes word is zero
  localparam logic [15:0] SEED_A_FALLBACK = 16'h8d0e;
  localparam logic [15:0] SEED_B_FALLBACK = 16'h9f81;

  // ASCII codes of interest
  localparam logic [7:0] CHAR_NUL   = 8'd0;
  localparam logic [7:0] CHAR_ETX   = 8'd3;
  localparam logic [7:0] CHAR_BS    = 8'd8;
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_TILDE = 8'd126;
  localparam logic [7:0] DEL_CODE   = 8'd127;
  localparam logic [7:0] CHAR_MAX   = 8'd255;

  // Extended scan codes and the game codes they turn into
  localparam logic [7:0] SCAN_UP     = 8'd72;
  localparam logic [7:0] SCAN_DOWN   = 8'd80;
  localparam logic [7:0] SCAN_LEFT   = 8'd75;
  localparam logic [7:0] SCAN_RIGHT  = 8'd77;
  localparam logic [7:0] SCAN_F1     = 8'd59;
  localparam logic [7:0] SCAN_F10    = 8'd68;
  localparam logic [7:0] GAME_UP     = 8'd129;
  localparam logic [7:0] GAME_DOWN   = 8'd130;
  localparam logic [7:0] GAME_LEFT   = 8'd131;
  localparam logic [7:0] GAME_RIGHT  = 8'd132;
  localparam logic [7:0] FKEY_OFFSET = 8'd74;

  // Translated key with its abort flag
  typedef struct packed {
    logic [7:0] code;
    logic       abort;
  } key_t;

  // One finished result
  typedef struct packed {
    logic [7:0]  key_char;
    logic        abort_request;
    logic [14:0] random_value;
  } res_t;

endpackage
`default_nettype wire

/* rtl/kts_keymap.sv */
`timescale 1ns / 1ps
`default_nettype none
module kts_keymap (
  input  wire logic [15:0]   key_word,
  output kts_pkg::key_t      key_out
);

  logic [7:0] lo;
  logic [7:0] hi;

  assign lo = key_word[7:0];
  assign hi = key_word[15:8];

  // Translate plain ASCII by low byte, extended keys by scan code
  always_comb begin
    key_out.code  = kts_pkg::CHAR_NUL;
    key_out.abort = 1'b0;
    if (lo != kts_pkg::CHAR_NUL) begin
      case (lo) inside
        [kts_pkg::CHAR_SPACE:kts_pkg::CHAR_TILDE]: key_out.code = lo;
        [kts_pkg::DEL_CODE:kts_pkg::CHAR_MAX]:     key_out.code = kts_pkg::CHAR_BS;
        kts_pkg::CHAR_CR, kts_pkg::CHAR_LF:        key_out.code = kts_pkg::CHAR_CR;
        kts_pkg::CHAR_BS:                          key_out.code = kts_pkg::CHAR_BS;
        kts_pkg::CHAR_ETX:                         key_out.abort = 1'b1;
        default:                                   key_out.code = kts_pkg::CHAR_NUL;
      endcase
    end else begin
      case (hi) inside
        kts_pkg::SCAN_UP:    key_out.code = kts_pkg::GAME_UP;
        kts_pkg::SCAN_DOWN:  key_out.code = kts_pkg::GAME_DOWN;
        kts_pkg::SCAN_LEFT:  key_out.code = kts_pkg::GAME_LEFT;
        kts_pkg::SCAN_RIGHT: key_out.code = kts_pkg::GAME_RIGHT;
        [kts_pkg::SCAN_F1:kts_pkg::SCAN_F10]: key_out.code = hi + kts_pkg::FKEY_OFFSET;
        default:             key_out.code = kts_pkg::CHAR_NUL;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/kts_seed.sv */
`timescale 1ns / 1ps
`default_nettype none
module kts_seed (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            advance,
  input  wire kts_pkg::kind_t  kind,
  input  wire kts_pkg::key_t   key_in,
  input  wire logic [15:0]     time_hi,
  input  wire logic [15:0]     time_lo,
  output kts_pkg::res_t        res
);

  logic [15:0] seed_a_r;
  logic [15:0] seed_b_r;
  logic [15:0] seed_a_nxt;
  logic [15:0] seed_b_nxt;
  logic [15:0] key_sum;

  assign key_sum = seed_a_r + {8'd0, key_in.code};

  // Work out the seed update and the result for the item at hand
  always_comb begin
    seed_a_nxt = seed_a_r;
    seed_b_nxt = seed_b_r;
    res        = '0;
    case (kind)
      kts_pkg::KIND_SEED: begin
        if (time_hi == 16'd0) begin
          seed_a_nxt = kts_pkg::SEED_A_FALLBACK;
          seed_b_nxt = kts_pkg::SEED_B_FALLBACK;
        end else begin
          seed_a_nxt = time_hi;
          seed_b_nxt = time_lo;
        end
      end
      kts_pkg::KIND_KEY: begin
        res.key_char      = key_in.code;
        res.abort_request = key_in.abort;
        if (!key_in.abort) begin
          seed_a_nxt = key_sum;
          seed_b_nxt = seed_b_r ^ key_sum;
        end
      end
      kts_pkg::KIND_RAND: begin
        // Shift both seeds right as one 32-bit word pair, fold, swap
        seed_a_nxt       = {1'b0, seed_a_r[15:1]} ^ {seed_a_r[0], seed_b_r[15:1]};
        seed_b_nxt       = seed_a_r;
        res.random_value = seed_a_nxt[14:0];
      end
      default: begin
        res = '0;
      end
    endcase
  end

  // Commit the update when the item moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_a_r <= 16'd0;
      seed_b_r <= 16'd0;
    end else if (advance) begin
      seed_a_r <= seed_a_nxt;
      seed_b_r <= seed_b_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/key_translate_with_shift_xor_random_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Keyboard translator and shift/XOR random source. Each request on the
// input stream (kind in in_tuser) gives exactly one result, in order:
// a seed load, a key translation that also stirs the seeds, or a 15-bit
// random number. The block takes one request per cycle while the result
// side does not stall it. A request is first held in the input register;
// the seed update, a single add or shift/XOR, then lands in the result
// register, which holds the result until it is taken. Back-pressure from
// the result side stalls the input register only once both registers
// hold a request.
module key_translate_with_shift_xor_random_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,  // key_word[15:0], time_hi[31:16], time_lo[47:32]
  input  wire logic [1:0]  in_tuser,  // kind[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata, // key_char[7:0], random_value[22:8], zero[23]
  output logic             out_tuser  // abort_request[0]
);

  logic           s1_valid_r;
  kts_pkg::kind_t s1_kind_r;
  logic [15:0]    s1_key_r;
  logic [15:0]    s1_thi_r;
  logic [15:0]    s1_tlo_r;
  logic           out_valid_r;
  kts_pkg::res_t  out_res_r;
  logic           out_free;
  logic           advance;
  kts_pkg::key_t  key_map;
  kts_pkg::res_t  res_nxt;

  // Move a request forward when the result register is free or drains
  assign out_free  = !out_valid_r || out_tready;
  assign advance   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  // Hold the accepted request in the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_kind_r <= kts_pkg::kind_t'(in_tuser);
      s1_key_r  <= in_tdata[15:0];
      s1_thi_r  <= in_tdata[31:16];
      s1_tlo_r  <= in_tdata[47:32];
    end
  end

  kts_keymap u_keymap (
    .key_word (s1_key_r),
    .key_out  (key_map)
  );

  kts_seed u_seed (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .kind    (s1_kind_r),
    .key_in  (key_map),
    .time_hi (s1_thi_r),
    .time_lo (s1_tlo_r),
    .res     (res_nxt)
  );

  // Load the result register; drop valid once the result is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r.random_value, out_res_r.key_char};
  assign out_tuser  = out_res_r.abort_request;

endmodule
`default_nettype wire

/* rtl/kts_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module kts_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [23:0] out_tdata,
  input  wire logic        out_tuser
);

  // Leave reset with no result pending
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // Hold a stalled result
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // An abort carries no character and no random number
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 24'd0)
    else $error("abort result with nonzero data");

  // A key result and a random result never share one request
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[7:0] != 8'd0 |-> out_tdata[23:8] == 16'd0)
    else $error("key code and random value both set");

  // With an empty result register the input side is open
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid && $past(rst_n) && !($past(in_tvalid) && $past(in_tready)) |-> in_tready)
    else $error("input stalled with nothing in flight");

endmodule

bind key_translate_with_shift_xor_random_core kts_checker u_kts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
